@@ hdl/zfu_pkg.sv @@
// Shared types and constants for the Z80 flag unit.
// No dependencies; imported by zfu_flag_calc and z80_flag_unit.
`default_nettype none

package zfu_pkg;

   typedef enum logic [4:0] {
      FUNC_ADD8      = 5'd0,
      FUNC_SUB8      = 5'd1,
      FUNC_CP        = 5'd2,
      FUNC_LOGIC     = 5'd3,
      FUNC_INC       = 5'd4,
      FUNC_DEC       = 5'd5,
      FUNC_ADD16     = 5'd6,
      FUNC_ADC16     = 5'd7,
      FUNC_SBC16     = 5'd8,
      FUNC_BIT       = 5'd9,
      FUNC_ROTA      = 5'd10,
      FUNC_SHIFT     = 5'd11,
      FUNC_DAA       = 5'd12,
      FUNC_CPL       = 5'd13,
      FUNC_NEG       = 5'd14,
      FUNC_CCF       = 5'd15,
      FUNC_SCF       = 5'd16,
      FUNC_BLOCKXFER = 5'd17,
      FUNC_IN        = 5'd18,
      FUNC_BLOCKIO   = 5'd19
   } func_type;

   localparam logic [7:0] MASK_ALL   = 8'hFF;
   localparam logic [7:0] MASK_NO_C  = 8'hFE;
   localparam logic [7:0] MASK_ADD16 = 8'h3B;
   localparam logic [7:0] MASK_CPL   = 8'h3A;
   localparam logic [7:0] MASK_DAA   = 8'hFD;
   localparam logic [7:0] MASK_XFER  = 8'h3E;
   localparam logic [7:0] MASK_NONE  = 8'h00;

   localparam int FLAG_C = 0;
   localparam int FLAG_H = 4;
   localparam int FLAG_N = 1;

   typedef struct packed {
      logic [4:0]  func;
      logic [7:0]  acc;
      logic [15:0] operand_a;
      logic [16:0] operand_b;
      logic [2:0]  bit_arg;
      logic        is_and;
      logic        count_nonzero;
   } req_item_type;

   typedef struct packed {
      logic [7:0] new_flags;
      logic [7:0] mask;
   } flag_upd_type;

endpackage

`default_nettype wire

@@ hdl/zfu_flag_calc.sv @@
// Combinational flag computation for one transaction: new flag values and write mask.
// Depends on zfu_pkg for the operation codes, item and update types.
`default_nettype none

module zfu_flag_calc
   import zfu_pkg::*;
(
   input  req_item_type item,
   input  logic [7:0]   flag_reg,
   output flag_upd_type upd
);

   function automatic logic [7:0] pack(input logic c, input logic n, input logic pv,
                                       input logic h, input logic z, input logic s,
                                       input logic [7:0] f35);
      return {s, z, f35[5], h, f35[3], pv, n, c};
   endfunction

   function automatic logic parity_even(input logic [7:0] v);
      return ~(^v);
   endfunction

   function automatic logic ovf(input logic l7, input logic r7, input logic s7,
                                input logic sub);
      if (sub) begin
         return (~l7 & r7 & s7) | (l7 & ~r7 & ~s7);
      end
      return (~l7 & ~r7 & s7) | (l7 & r7 & ~s7);
   endfunction

   function automatic logic [7:0] arith8(input logic [7:0] lh, input logic [15:0] rh,
                                         input logic sub);
      logic [16:0] raw;
      logic [4:0]  hn;
      logic [7:0]  res;
      raw = sub ? ({9'd0, lh} - {1'b0, rh}) : ({9'd0, lh} + {1'b0, rh});
      hn  = sub ? ({1'b0, lh[3:0]} - {1'b0, rh[3:0]}) : ({1'b0, lh[3:0]} + {1'b0, rh[3:0]});
      res = raw[7:0];
      return pack(raw[8], sub, ovf(lh[7], rh[7], res[7], sub), hn[4], res == 8'd0,
                  res[7], res);
   endfunction

   function automatic logic [7:0] arith16(input logic [15:0] lh, input logic [16:0] rh,
                                          input logic sub);
      logic [17:0] raw;
      logic [4:0]  hn;
      logic [15:0] res;
      raw = sub ? ({2'd0, lh} - {1'b0, rh}) : ({2'd0, lh} + {1'b0, rh});
      hn  = sub ? ({1'b0, lh[11:8]} - {1'b0, rh[11:8]})
                : ({1'b0, lh[11:8]} + {1'b0, rh[11:8]});
      res = raw[15:0];
      return pack(raw[16], sub, ovf(lh[15], rh[15], res[15], sub), hn[4],
                  res == 16'd0, res[15], res[15:8]);
   endfunction

   function automatic logic [7:0] logic_like(input logic [7:0] res, input logic c,
                                             input logic h);
      return pack(c, 1'b0, parity_even(res), h, res == 8'd0, res[7], res);
   endfunction

   logic [7:0]  a8;
   logic [16:0] sum16;
   logic [4:0]  hn16;
   logic        bit_zero;
   logic [7:0]  xfer_sum;
   logic        daa_h;
   logic [7:0]  neg_rh;

   assign a8       = item.operand_a[7:0];
   assign sum16    = {1'b0, item.operand_a} + {1'b0, item.operand_b[15:0]};
   assign hn16     = {1'b0, item.operand_a[11:8]} + {1'b0, item.operand_b[11:8]};
   assign bit_zero = ~a8[item.bit_arg];
   assign xfer_sum = a8 + item.acc;
   assign daa_h    = flag_reg[FLAG_N] ? (flag_reg[FLAG_H] && (a8[3:0] < 4'h6))
                                      : (a8[3:0] > 4'h9);
   assign neg_rh   = 8'd0 - item.acc;

   always_comb begin
      upd.new_flags = 8'd0;
      upd.mask      = MASK_NONE;
      case (item.func)
         FUNC_ADD8: begin
            upd.new_flags = arith8(item.acc, item.operand_b[15:0], 1'b0);
            upd.mask      = MASK_ALL;
         end
         FUNC_SUB8: begin
            upd.new_flags = arith8(item.acc, item.operand_b[15:0], 1'b1);
            upd.mask      = MASK_ALL;
         end
         FUNC_CP: begin
            upd.new_flags = (arith8(item.acc, item.operand_b[15:0], 1'b1) & 8'hD7)
                            | (item.operand_b[7:0] & 8'h28);
            upd.mask      = MASK_ALL;
         end
         FUNC_LOGIC: begin
            upd.new_flags = logic_like(a8, 1'b0, item.is_and);
            upd.mask      = MASK_ALL;
         end
         FUNC_INC: begin
            upd.new_flags = arith8(a8, 16'd1, 1'b0);
            upd.mask      = MASK_NO_C;
         end
         FUNC_DEC, FUNC_BLOCKIO: begin
            upd.new_flags = arith8(a8, 16'd1, 1'b1);
            upd.mask      = MASK_NO_C;
         end
         FUNC_ADD16: begin
            upd.new_flags = pack(sum16[16], 1'b0, 1'b0, hn16[4], 1'b0, 1'b0, sum16[15:8]);
            upd.mask      = MASK_ADD16;
         end
         FUNC_ADC16: begin
            upd.new_flags = arith16(item.operand_a, item.operand_b, 1'b0);
            upd.mask      = MASK_ALL;
         end
         FUNC_SBC16: begin
            upd.new_flags = arith16(item.operand_a, item.operand_b, 1'b1);
            upd.mask      = MASK_ALL;
         end
         FUNC_BIT: begin
            upd.new_flags = pack(1'b0, 1'b0, bit_zero, 1'b1, bit_zero,
                                 ~bit_zero && (item.bit_arg == 3'd7),
                                 {2'b00, ~bit_zero && (item.bit_arg == 3'd5), 1'b0,
                                  ~bit_zero && (item.bit_arg == 3'd3), 3'b000});
            upd.mask      = MASK_NO_C;
         end
         FUNC_ROTA: begin
            upd.new_flags = pack(item.bit_arg != 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 item.acc);
            upd.mask      = MASK_ADD16;
         end
         FUNC_SHIFT: begin
            upd.new_flags = logic_like(a8, item.bit_arg != 3'd0, 1'b0);
            upd.mask      = MASK_ALL;
         end
         FUNC_DAA: begin
            upd.new_flags = logic_like(item.acc, item.operand_b[7:0] >= 8'h60, daa_h);
            upd.mask      = MASK_DAA;
         end
         FUNC_CPL: begin
            upd.new_flags = pack(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, item.acc);
            upd.mask      = MASK_CPL;
         end
         FUNC_NEG: begin
            upd.new_flags = (arith8(8'd0, {8'd0, neg_rh}, 1'b1) & 8'hD7)
                            | (item.acc & 8'h28);
            upd.mask      = MASK_ALL;
         end
         FUNC_CCF: begin
            upd.new_flags = pack(~flag_reg[FLAG_C], 1'b0, 1'b0, flag_reg[FLAG_C], 1'b0,
                                 1'b0, item.acc);
            upd.mask      = MASK_ADD16;
         end
         FUNC_SCF: begin
            upd.new_flags = pack(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, item.acc);
            upd.mask      = MASK_ADD16;
         end
         FUNC_BLOCKXFER: begin
            upd.new_flags = pack(1'b0, 1'b0, item.count_nonzero, 1'b0, 1'b0, 1'b0,
                                 {2'b00, xfer_sum[1], 1'b0, xfer_sum[3], 3'b000});
            upd.mask      = MASK_XFER;
         end
         FUNC_IN: begin
            upd.new_flags = logic_like(a8, 1'b0, 1'b0);
            upd.mask      = MASK_NO_C;
         end
         default: begin
            upd.new_flags = 8'd0;
            upd.mask      = MASK_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/z80_flag_unit.sv @@
// Z80 flag register unit: input register, flag computation, flag and result registers.
// A request is held in the input register, then moves to the response register when it is free.
// Throughput: one transaction per cycle while rsp_ready is high; the stored flags update as an item
// moves from the input register into the response register.
// Reset clears the flag register and both valid bits.
// Depends on zfu_pkg and zfu_flag_calc.
`default_nettype none

module z80_flag_unit
   import zfu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_func,
   input  logic [7:0]  req_acc,
   input  logic [15:0] req_operand_a,
   input  logic [16:0] req_operand_b,
   input  logic [2:0]  req_bit_arg,
   input  logic        req_is_and,
   input  logic        req_count_nonzero,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_flags
);

   req_item_type item_ff, item_in;
   logic         in_valid_ff, in_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_flags_ff, rsp_flags_in;
   logic [7:0]   flag_reg_ff, flag_reg_in;
   flag_upd_type upd;
   logic         advance;
   logic         req_take;

   zfu_flag_calc u_calc (
      .item     (item_ff),
      .flag_reg (flag_reg_ff),
      .upd      (upd)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      item_in      = item_ff;
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_flags_in = rsp_flags_ff;
      flag_reg_in  = flag_reg_ff;
      if (req_take) begin
         item_in = '{func: req_func, acc: req_acc, operand_a: req_operand_a,
                     operand_b: req_operand_b, bit_arg: req_bit_arg,
                     is_and: req_is_and, count_nonzero: req_count_nonzero};
      end
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (advance) begin
         flag_reg_in  = (flag_reg_ff & ~upd.mask) | (upd.new_flags & upd.mask);
         rsp_flags_in = (flag_reg_ff & ~upd.mask) | (upd.new_flags & upd.mask);
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rsp_flags_ff <= rsp_flags_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flag_reg_ff  <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flag_reg_ff  <= flag_reg_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_flags = rsp_flags_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff && (flag_reg_ff == 8'd0))
      else $error("reset did not clear pipeline state");

   a_rsp_tracks_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_flags_ff == flag_reg_ff))
      else $error("pending response differs from stored flags");

   a_flags_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(flag_reg_ff))
      else $error("flag register changed without a transaction");

   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("empty input stage refused a request");

endmodule

`default_nettype wire

@@ tb/tb_z80_flag_unit.sv @@
// Self-checking testbench for z80_flag_unit: directed and random flag operations
// with random stalls on both handshakes, checked against a flag predictor.
// Depends on zfu_pkg and the z80_flag_unit RTL.
`timescale 1ns / 100ps

module tb_z80_flag_unit;
   import zfu_pkg::*;

   localparam logic [4:0] FUNC_UNUSED_LO = 5'd20;
   localparam logic [4:0] FUNC_UNUSED_HI = 5'd31;
   localparam int         CYCLE_LIMIT    = 500000;
   localparam int         RANDOM_ITEMS   = 1000;

   class flag_scoreboard;
      logic [7:0] flag_state;
      logic [7:0] expected_flags[$];
      int         errors;

      function new();
         flag_state = 8'h00;
         errors     = 0;
      endfunction

      function logic [7:0] pack_flags(bit c, bit n, bit pv, bit h, bit z, bit s,
                                      logic [7:0] f35);
         return {s, z, f35[5], h, f35[3], pv, n, c};
      endfunction

      function bit overflow(bit l7, bit r7, bit s7, bit sub);
         if (sub)
            return (!l7 && r7 && s7) || (l7 && !r7 && !s7);
         return (!l7 && !r7 && s7) || (l7 && r7 && !s7);
      endfunction

      function logic [7:0] arith8(logic [31:0] lh, logic [31:0] rh, bit sub);
         logic [31:0] raw;
         logic [31:0] hn;
         logic [7:0]  res;
         raw = sub ? lh - rh : lh + rh;
         res = raw[7:0];
         hn  = sub ? {28'd0, lh[3:0]} - {28'd0, rh[3:0]} : {28'd0, lh[3:0]} + {28'd0, rh[3:0]};
         return pack_flags(raw[8], sub, overflow(lh[7], rh[7], res[7], sub), hn[4],
                           res == 8'h00, res[7], res);
      endfunction

      function logic [7:0] arith16(logic [31:0] lh, logic [31:0] rh, bit sub);
         logic [31:0] raw;
         logic [31:0] hn;
         logic [15:0] res;
         raw = sub ? lh - rh : lh + rh;
         res = raw[15:0];
         hn  = sub ? {28'd0, lh[11:8]} - {28'd0, rh[11:8]}
                   : {28'd0, lh[11:8]} + {28'd0, rh[11:8]};
         return pack_flags(raw[16], sub, overflow(lh[15], rh[15], res[15], sub), hn[4],
                           res == 16'h0000, res[15], res[15:8]);
      endfunction

      function logic [7:0] logic_flags(logic [7:0] res, bit c, bit h);
         return pack_flags(c, 1'b0, ~^res, h, res == 8'h00, res[7], res);
      endfunction

      function logic [7:0] next_flags(logic [4:0] func, logic [7:0] acc, logic [15:0] opa,
                                      logic [16:0] opb, logic [2:0] bit_idx, bit is_and,
                                      bit cnz);
         logic [7:0]  a8;
         logic [7:0]  nf;
         logic [7:0]  mask;
         logic [7:0]  sum8;
         logic [31:0] raw;
         logic [4:0]  hn;
         bit          z;
         bit          h;
         a8   = opa[7:0];
         nf   = 8'h00;
         mask = MASK_NONE;
         case (func)
            FUNC_ADD8: begin
               nf = arith8({24'd0, acc}, {16'd0, opb[15:0]}, 1'b0); mask = MASK_ALL;
            end
            FUNC_SUB8: begin
               nf = arith8({24'd0, acc}, {16'd0, opb[15:0]}, 1'b1); mask = MASK_ALL;
            end
            FUNC_CP: begin
               nf = (arith8({24'd0, acc}, {16'd0, opb[15:0]}, 1'b1) & 8'hD7)
                    | (opb[7:0] & 8'h28);
               mask = MASK_ALL;
            end
            FUNC_LOGIC: begin
               nf = logic_flags(a8, 1'b0, is_and); mask = MASK_ALL;
            end
            FUNC_INC: begin
               nf = arith8({24'd0, a8}, 32'd1, 1'b0); mask = MASK_NO_C;
            end
            FUNC_DEC, FUNC_BLOCKIO: begin
               nf = arith8({24'd0, a8}, 32'd1, 1'b1); mask = MASK_NO_C;
            end
            FUNC_ADD16: begin
               raw  = {16'd0, opa} + {16'd0, opb[15:0]};
               hn   = {1'b0, opa[11:8]} + {1'b0, opb[11:8]};
               nf   = pack_flags(raw[16], 1'b0, 1'b0, hn[4], 1'b0, 1'b0, raw[15:8]);
               mask = MASK_ADD16;
            end
            FUNC_ADC16: begin
               nf = arith16({16'd0, opa}, {15'd0, opb}, 1'b0); mask = MASK_ALL;
            end
            FUNC_SBC16: begin
               nf = arith16({16'd0, opa}, {15'd0, opb}, 1'b1); mask = MASK_ALL;
            end
            FUNC_BIT: begin
               z    = !a8[bit_idx];
               nf   = pack_flags(1'b0, 1'b0, z, 1'b1, z, !z && bit_idx == 3'd7,
                                 {2'b00, !z && bit_idx == 3'd5, 1'b0, !z && bit_idx == 3'd3,
                                  3'b000});
               mask = MASK_NO_C;
            end
            FUNC_ROTA: begin
               nf = pack_flags(bit_idx != 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, acc);
               mask = MASK_ADD16;
            end
            FUNC_SHIFT: begin
               nf = logic_flags(a8, bit_idx != 3'd0, 1'b0); mask = MASK_ALL;
            end
            FUNC_DAA: begin
               h = flag_state[FLAG_N] ? (flag_state[FLAG_H] && a8[3:0] < 4'h6)
                                      : (a8[3:0] > 4'h9);
               nf   = logic_flags(acc, opb[7:0] >= 8'h60, h);
               mask = MASK_DAA;
            end
            FUNC_CPL: begin
               nf = pack_flags(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, acc); mask = MASK_CPL;
            end
            FUNC_NEG: begin
               nf = (arith8(32'd0, {24'd0, 8'd0 - acc}, 1'b1) & 8'hD7) | (acc & 8'h28);
               mask = MASK_ALL;
            end
            FUNC_CCF: begin
               nf = pack_flags(!flag_state[FLAG_C], 1'b0, 1'b0, flag_state[FLAG_C],
                               1'b0, 1'b0, acc);
               mask = MASK_ADD16;
            end
            FUNC_SCF: begin
               nf = pack_flags(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, acc); mask = MASK_ADD16;
            end
            FUNC_BLOCKXFER: begin
               sum8 = a8 + acc;
               nf   = pack_flags(1'b0, 1'b0, cnz, 1'b0, 1'b0, 1'b0,
                                 {2'b00, sum8[1], 1'b0, sum8[3], 3'b000});
               mask = MASK_XFER;
            end
            FUNC_IN: begin
               nf = logic_flags(a8, 1'b0, 1'b0); mask = MASK_NO_C;
            end
            default: begin
               nf = 8'h00; mask = MASK_NONE;
            end
         endcase
         flag_state = (flag_state & ~mask) | (nf & mask);
         return flag_state;
      endfunction

      function void note_request(logic [4:0] func, logic [7:0] acc, logic [15:0] opa,
                                 logic [16:0] opb, logic [2:0] bit_idx, bit is_and, bit cnz);
         expected_flags.push_back(next_flags(func, acc, opa, opb, bit_idx, is_and, cnz));
      endfunction

      function void check_flags(logic [7:0] actual);
         logic [7:0] expected;
         if (expected_flags.size() == 0) begin
            $display("%0t: unexpected response transaction, flags %02h", $time, actual);
            errors++;
         end else begin
            expected = expected_flags.pop_front();
            if (actual !== expected) begin
               $display("%0t: flags mismatch, expected %02h actual %02h",
                        $time, expected, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [4:0]  req_func;
   logic [7:0]  req_acc;
   logic [15:0] req_operand_a;
   logic [16:0] req_operand_b;
   logic [2:0]  req_bit_arg;
   logic        req_is_and;
   logic        req_count_nonzero;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_flags;

   flag_scoreboard sb = new();
   bit             steady;
   int             cycle_count;

   z80_flag_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_acc           (req_acc),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .req_bit_arg       (req_bit_arg),
      .req_is_and        (req_is_and),
      .req_count_nonzero (req_count_nonzero),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_flags         (rsp_flags)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input logic [4:0] func, input logic [7:0] acc,
                               input logic [15:0] opa, input logic [16:0] opb,
                               input logic [2:0] bit_idx, input logic is_and,
                               input logic cnz);
      int gap;
      req_valid         <= 1'b1;
      req_func          <= func;
      req_acc           <= acc;
      req_operand_a     <= opa;
      req_operand_b     <= opb;
      req_bit_arg       <= bit_idx;
      req_is_and        <= is_and;
      req_count_nonzero <= cnz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(func, acc, opa, opb, bit_idx, is_and, cnz);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      logic [4:0]  func;
      logic [16:0] opb;
      if ($urandom_range(0, 9) == 0)
         func = 5'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
      else
         func = 5'($urandom_range(FUNC_ADD8, FUNC_BLOCKIO));
      opb = ($urandom_range(0, 19) == 0) ? 17'h10000 : 17'($urandom_range(0, 16'hFFFF));
      send_request(func, 8'($urandom), 16'($urandom), opb, 3'($urandom),
                   1'($urandom), 1'($urandom));
   endtask

   // hold rsp_ready in random runs of ready and stall
   initial begin
      int hold;
      hold = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold == 0) begin
            if (steady || $urandom_range(0, 3) != 0) begin
               rsp_ready <= 1'b1;
               hold = $urandom_range(1, 16);
            end else begin
               rsp_ready <= 1'b0;
               hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            end
         end
         hold--;
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_flags(rsp_flags);
      end
   end

   initial begin
      reset             = 1'b1;
      steady            = 1'b0;
      req_valid         = 1'b0;
      req_func          = FUNC_ADD8;
      req_acc           = 8'h00;
      req_operand_a     = 16'h0000;
      req_operand_b     = 17'h00000;
      req_bit_arg       = 3'd0;
      req_is_and        = 1'b0;
      req_count_nonzero = 1'b0;
      rsp_ready         = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(FUNC_ADD8,      8'hFF, 16'h0000, 17'h00001, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_SUB8,      8'h80, 16'h0000, 17'h00001, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_SUB8,      8'h00, 16'h0000, 17'h0FFFF, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_CP,        8'h05, 16'h0000, 17'h00028, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_LOGIC,     8'h00, 16'h0000, 17'h00000, 3'd0, 1'b1, 1'b0);
      send_request(FUNC_INC,       8'h00, 16'h007F, 17'h00000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_DEC,       8'h00, 16'h0080, 17'h00000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_ADD16,     8'h00, 16'hFFFF, 17'h0FFFF, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_ADC16,     8'h00, 16'hFFFF, 17'h10000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_SBC16,     8'h00, 16'h0000, 17'h10000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_BIT,       8'h00, 16'h0080, 17'h00000, 3'd7, 1'b0, 1'b0);
      send_request(FUNC_BIT,       8'h00, 16'h0008, 17'h00000, 3'd3, 1'b0, 1'b0);
      send_request(FUNC_ROTA,      8'hFF, 16'h0000, 17'h00000, 3'd1, 1'b0, 1'b0);
      send_request(FUNC_SHIFT,     8'h00, 16'h0000, 17'h00000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_SUB8,      8'h10, 16'h0000, 17'h00001, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_DAA,       8'h9A, 16'h0003, 17'h00060, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_CPL,       8'h55, 16'h0000, 17'h00000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_NEG,       8'h80, 16'h0000, 17'h00000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_CCF,       8'h28, 16'h0000, 17'h00000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_SCF,       8'h00, 16'h0000, 17'h00000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_BLOCKXFER, 8'h0B, 16'h00FF, 17'h00000, 3'd0, 1'b0, 1'b1);
      send_request(FUNC_IN,        8'h00, 16'h0000, 17'h00000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_BLOCKIO,   8'h00, 16'h0001, 17'h00000, 3'd0, 1'b0, 1'b0);
      send_request(FUNC_UNUSED_LO, 8'hFF, 16'hFFFF, 17'h1FFFF, 3'd7, 1'b1, 1'b1);
      send_request(FUNC_UNUSED_HI, 8'h00, 16'h0000, 17'h00000, 3'd0, 1'b0, 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 400 && i < 550);
         send_random();
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (sb.expected_flags.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
